>>> rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared constants and types for the pixel color statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcs_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int FIELD_W      = 8;
    localparam int COLOR_BITS   = 3 * CHANNEL_BITS;
    localparam int BRIGHT_W     = CHANNEL_BITS + 2;

    localparam int WORD_LOG  = 5;
    localparam int WORD_BITS = 1 << WORD_LOG;
    localparam int ROW_AW    = COLOR_BITS - WORD_LOG;
    localparam int ROWS      = 1 << ROW_AW;
    localparam int EPOCH_W   = 8;
    localparam int MEM_W     = EPOCH_W + WORD_BITS;

    localparam int SUM_W   = 32;
    localparam int COUNT_W = 25;

    localparam logic [COUNT_W-1:0] MAX_PIXELS  = COUNT_W'(64'd16777216);
    localparam logic [COUNT_W-1:0] COLOR_COUNT = COUNT_W'(64'd1 << COLOR_BITS);
    localparam logic [SUM_W-1:0]   SUM_CAP     =
        SUM_W'(((64'd1 << CHANNEL_BITS) - 64'd1) * 64'(MAX_PIXELS));

    localparam logic [EPOCH_W-1:0] FIRST_EPOCH = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] LAST_EPOCH  = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam int IN_TDATA_W  = 3 * FIELD_W;
    localparam int RESULT_BITS = 2 * COUNT_W + 3 * SUM_W + 3 * FIELD_W;
    localparam int OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RESULT_BITS;

    typedef struct packed {
        logic                    last;
        logic [BRIGHT_W-1:0]     bright;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] red;
        logic [ROW_AW-1:0]       row;
        logic [WORD_LOG-1:0]     bit_sel;
    } pcs_item_t;

    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [FIELD_W-1:0]   bright_blue;
        logic [FIELD_W-1:0]   bright_green;
        logic [FIELD_W-1:0]   bright_red;
        logic [SUM_W-1:0]     blue_total;
        logic [SUM_W-1:0]     green_total;
        logic [SUM_W-1:0]     red_total;
        logic [COUNT_W-1:0]   pixel_total;
        logic [COUNT_W-1:0]   distinct_colors;
    } pcs_result_t;

    typedef struct packed {
        logic      valid;
        pcs_item_t item;
    } pcs_head_t;

endpackage

`default_nettype wire

>>> rtl/pcs_front.sv
// ----------------------------------------------------------------------------
// pcs_front
// Input side: takes pixel beats, masks the channels, forms the bitmap
// row and bit position and the channel sum, and pushes the item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_front (
    input  wire logic                           clearing,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pcs_pkg::IN_TDATA_W-1:0] s_tdata,   // red, green, blue
    input  wire logic                           s_tlast,   // last_pixel
    input  wire logic                           q_full,
    output logic                                q_push,
    output pcs_pkg::pcs_item_t                  q_item
);
    import pcs_pkg::*;

    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [COLOR_BITS-1:0]   color_idx;

    assign red       = s_tdata[0 +: CHANNEL_BITS];
    assign green     = s_tdata[FIELD_W +: CHANNEL_BITS];
    assign blue      = s_tdata[2 * FIELD_W +: CHANNEL_BITS];
    assign color_idx = {blue, green, red};

    assign s_tready = !q_full && !clearing;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_item.last    = s_tlast;
        q_item.bright  = BRIGHT_W'(red) + BRIGHT_W'(green) + BRIGHT_W'(blue);
        q_item.red     = red;
        q_item.green   = green;
        q_item.blue    = blue;
        q_item.row     = color_idx[COLOR_BITS-1:WORD_LOG];
        q_item.bit_sel = color_idx[WORD_LOG-1:0];
    end

endmodule

`default_nettype wire

>>> rtl/pcs_queue.sv
// ----------------------------------------------------------------------------
// pcs_queue
// Short first-in first-out queue of classified pixels between the input
// side and the statistics engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire pcs_pkg::pcs_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output pcs_pkg::pcs_head_t      head
);
    import pcs_pkg::*;

    pcs_item_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcs_back.sv
// ----------------------------------------------------------------------------
// pcs_back
// Statistics engine: channel sums, pixel count, brightest pixel and the
// distinct color bitmap, kept in an epoch-tagged memory, plus the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcs_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire pcs_pkg::pcs_head_t              q_head,
    output logic                                 q_pop,
    output logic                                 clearing,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pcs_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import pcs_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                                 input logic [CHANNEL_BITS-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W + 1)'(v);
        return (s > (SUM_W + 1)'(SUM_CAP)) ? SUM_CAP : s[SUM_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] acc,
                                                   input logic [COUNT_W-1:0] cap);
        return (acc >= cap) ? cap : acc + 1'b1;
    endfunction

    logic [MEM_W-1:0] bitmap_mem [ROWS];

    state_t              state_reg;
    state_t              state_next;
    logic [ROW_AW-1:0]   clr_cnt_reg;
    logic [ROW_AW-1:0]   clr_cnt_next;
    logic [EPOCH_W-1:0]  epoch_reg;
    logic [EPOCH_W-1:0]  epoch_next;
    pcs_item_t           item_reg;
    logic [MEM_W-1:0]    rd_data_reg;

    logic [SUM_W-1:0]    red_acc_reg;
    logic [SUM_W-1:0]    green_acc_reg;
    logic [SUM_W-1:0]    blue_acc_reg;
    logic [COUNT_W-1:0]  pixel_acc_reg;
    logic [COUNT_W-1:0]  distinct_acc_reg;
    logic [COLOR_BITS-1:0] best_color_reg;
    logic [BRIGHT_W-1:0] best_sum_reg;

    logic [SUM_W-1:0]    red_acc_next;
    logic [SUM_W-1:0]    green_acc_next;
    logic [SUM_W-1:0]    blue_acc_next;
    logic [COUNT_W-1:0]  pixel_acc_next;
    logic [COUNT_W-1:0]  distinct_acc_next;
    logic [COLOR_BITS-1:0] best_color_next;
    logic [BRIGHT_W-1:0] best_sum_next;

    logic [SUM_W-1:0]    red_upd;
    logic [SUM_W-1:0]    green_upd;
    logic [SUM_W-1:0]    blue_upd;
    logic [COUNT_W-1:0]  pixel_upd;
    logic [COUNT_W-1:0]  distinct_upd;
    logic [COLOR_BITS-1:0] best_color_upd;
    logic [BRIGHT_W-1:0] best_sum_upd;

    logic [WORD_BITS-1:0] row_bits;
    logic [WORD_BITS-1:0] row_bits_new;
    logic                 color_seen;

    logic                mem_we;
    logic                mem_re;
    logic [ROW_AW-1:0]   mem_addr;
    logic [MEM_W-1:0]    mem_wdata;

    logic                m_valid_reg;
    logic                m_valid_next;
    pcs_result_t         out_reg;
    pcs_result_t         out_next;

    assign clearing = state_reg == ST_CLEAR;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    // stale epoch tag means the row is empty for this image
    always_comb begin
        row_bits     = (rd_data_reg[MEM_W-1 -: EPOCH_W] == epoch_reg) ?
                       rd_data_reg[WORD_BITS-1:0] : '0;
        color_seen   = row_bits[item_reg.bit_sel];
        row_bits_new = row_bits | (WORD_BITS'(1) << item_reg.bit_sel);

        red_upd      = sat_sum(red_acc_reg, item_reg.red);
        green_upd    = sat_sum(green_acc_reg, item_reg.green);
        blue_upd     = sat_sum(blue_acc_reg, item_reg.blue);
        pixel_upd    = sat_inc(pixel_acc_reg, MAX_PIXELS);
        distinct_upd = color_seen ? distinct_acc_reg :
                       sat_inc(distinct_acc_reg, COLOR_COUNT);
        if (item_reg.bright > best_sum_reg) begin
            best_color_upd = {item_reg.blue, item_reg.green, item_reg.red};
            best_sum_upd   = item_reg.bright;
        end else begin
            best_color_upd = best_color_reg;
            best_sum_upd   = best_sum_reg;
        end
    end

    always_comb begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        epoch_next        = epoch_reg;
        red_acc_next      = red_acc_reg;
        green_acc_next    = green_acc_reg;
        blue_acc_next     = blue_acc_reg;
        pixel_acc_next    = pixel_acc_reg;
        distinct_acc_next = distinct_acc_reg;
        best_color_next   = best_color_reg;
        best_sum_next     = best_sum_reg;
        q_pop             = 1'b0;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_addr          = q_head.item.row;
        mem_wdata         = '0;
        m_valid_next      = m_valid_reg && !m_tready;
        out_next          = out_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_AW'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // a last pixel waits until the result register is free
                if (q_head.valid && !(q_head.item.last && m_valid_reg)) begin
                    q_pop      = 1'b1;
                    mem_re     = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                mem_we     = 1'b1;
                mem_addr   = item_reg.row;
                mem_wdata  = {epoch_reg, row_bits_new};
                state_next = ST_IDLE;
                if (item_reg.last) begin
                    m_valid_next             = 1'b1;
                    out_next.pad             = '0;
                    out_next.distinct_colors = distinct_upd;
                    out_next.pixel_total     = pixel_upd;
                    out_next.red_total       = red_upd;
                    out_next.green_total     = green_upd;
                    out_next.blue_total      = blue_upd;
                    out_next.bright_red      = FIELD_W'(best_color_upd[0 +: CHANNEL_BITS]);
                    out_next.bright_green    =
                        FIELD_W'(best_color_upd[CHANNEL_BITS +: CHANNEL_BITS]);
                    out_next.bright_blue     =
                        FIELD_W'(best_color_upd[2 * CHANNEL_BITS +: CHANNEL_BITS]);
                    red_acc_next      = '0;
                    green_acc_next    = '0;
                    blue_acc_next     = '0;
                    pixel_acc_next    = '0;
                    distinct_acc_next = '0;
                    best_color_next   = '0;
                    best_sum_next     = '0;
                    if (epoch_reg == LAST_EPOCH) begin
                        epoch_next   = FIRST_EPOCH;
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end else begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end else begin
                    red_acc_next      = red_upd;
                    green_acc_next    = green_upd;
                    blue_acc_next     = blue_upd;
                    pixel_acc_next    = pixel_upd;
                    distinct_acc_next = distinct_upd;
                    best_color_next   = best_color_upd;
                    best_sum_next     = best_sum_upd;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            epoch_reg        <= FIRST_EPOCH;
            red_acc_reg      <= '0;
            green_acc_reg    <= '0;
            blue_acc_reg     <= '0;
            pixel_acc_reg    <= '0;
            distinct_acc_reg <= '0;
            best_color_reg   <= '0;
            best_sum_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            epoch_reg        <= epoch_next;
            red_acc_reg      <= red_acc_next;
            green_acc_reg    <= green_acc_next;
            blue_acc_reg     <= blue_acc_next;
            pixel_acc_reg    <= pixel_acc_next;
            distinct_acc_reg <= distinct_acc_next;
            best_color_reg   <= best_color_next;
            best_sum_reg     <= best_sum_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (q_pop) begin
            item_reg <= q_head.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= bitmap_mem[mem_addr];
        end
    end

    // the result register is always free when a last pixel is folded in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && item_reg.last) |-> !m_valid_reg)
        else $error("result register busy at last pixel");

    // no pixel leaves the queue while the bitmap is being swept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("pop during bitmap sweep");

    // the zero tag is reserved for swept rows
    assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != '0)
        else $error("epoch mark reached zero");

    // a color is new at most once per pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        distinct_acc_reg <= pixel_acc_reg)
        else $error("distinct count above pixel count");

    // a result is raised only by the update of a last pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_UPDATE && item_reg.last))
        else $error("result without last pixel");

endmodule

`default_nettype wire

>>> rtl/pixel_color_statistics.sv
// ----------------------------------------------------------------------------
// pixel_color_statistics
// Per-image color statistics over a stream of RGB pixels.
// ----------------------------------------------------------------------------
// In the statistics engine each pixel first reads its row of the distinct
// color bitmap from a single-port memory and then writes it back together
// with the sums, count and brightest pixel. A four-entry queue lets the
// input take beats while the engine works or while a result waits. The
// result beat appears in the cycle after the last pixel of an image has
// been folded in. Bitmap rows carry an image tag, so starting a new image
// costs nothing; after reset and after every 255th image the engine sweeps
// all 524288 bitmap rows, and no pixel is taken during that sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_color_statistics (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [pcs_pkg::IN_TDATA_W-1:0]   s_tdata,  // red, green, blue
    input  wire logic                             s_tlast,  // last_pixel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // distinct_colors, pixel_total, red_total, green_total, blue_total,
    // bright_red, bright_green, bright_blue, zero pad
    output logic [pcs_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import pcs_pkg::*;

    logic      clearing;
    logic      q_full;
    logic      q_push;
    logic      q_pop;
    pcs_item_t q_item;
    pcs_head_t q_head;

    pcs_front u_front (
        .clearing (clearing),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    pcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    pcs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> tb/sv/pixel_color_statistics_tb.sv
// ----------------------------------------------------------------------------
// pixel_color_statistics_tb
// Self-checking bench for the per-image color statistics block. Pixels are
// streamed in as images of varied length and content. Each accepted pixel is
// folded into a local model of the sums, pixel count, brightest pixel and
// distinct color set. Each result beat is checked against the oldest
// predicted image summary. Random gaps on both sides, with calm stretches.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_color_statistics_tb;

    localparam int          WATCHDOG_LIMIT = 2000000;
    localparam int          PIXEL_BUDGET   = 1950;
    localparam logic [31:0] SUM_LIMIT      = 32'hFF00_0000;
    localparam logic [24:0] PIXEL_LIMIT    = 25'h100_0000;

    logic aclk     = 1'b0;
    logic aresetn  = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [pcs_pkg::IN_TDATA_W-1:0] s_tdata = '0;  // red, green, blue
    logic s_tlast  = 1'b0;                          // last_pixel
    logic m_tvalid;
    logic m_tready = 1'b0;
    // distinct_colors, pixel_total, red_total, green_total, blue_total,
    // bright_red, bright_green, bright_blue, zero pad
    logic [pcs_pkg::OUT_TDATA_W-1:0] m_tdata;

    pixel_color_statistics dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // image statistics model
    logic [31:0] exp_red, exp_green, exp_blue;
    logic [24:0] pixel_count, distinct_count;
    logic [7:0]  best_red, best_green, best_blue;
    bit          seen_colors[bit [23:0]];

    pcs_pkg::pcs_result_t expected_stats[$];

    int  error_count  = 0;
    int  pixels_sent  = 0;
    bit  calm         = 1'b0;

    function automatic logic [31:0] sat_sum(logic [31:0] acc, logic [7:0] v);
        logic [32:0] s;
        s = {1'b0, acc} + 33'(v);
        return (s > 33'(SUM_LIMIT)) ? SUM_LIMIT : s[31:0];
    endfunction

    function automatic void clear_image();
        exp_red        = '0;
        exp_green      = '0;
        exp_blue       = '0;
        pixel_count    = '0;
        distinct_count = '0;
        best_red       = '0;
        best_green     = '0;
        best_blue      = '0;
        seen_colors.delete();
    endfunction

    function automatic void fold_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
        pcs_pkg::pcs_result_t summary;
        exp_red   = sat_sum(exp_red, r);
        exp_green = sat_sum(exp_green, g);
        exp_blue  = sat_sum(exp_blue, b);
        if (pixel_count < PIXEL_LIMIT)
            pixel_count = pixel_count + 25'd1;
        if (10'(r) + 10'(g) + 10'(b) > 10'(best_red) + 10'(best_green) + 10'(best_blue)) begin
            best_red   = r;
            best_green = g;
            best_blue  = b;
        end
        if (!seen_colors.exists({b, g, r})) begin
            seen_colors[{b, g, r}] = 1'b1;
            distinct_count = distinct_count + 25'd1;
        end
        if (last) begin
            summary                 = '0;
            summary.distinct_colors = distinct_count;
            summary.pixel_total     = pixel_count;
            summary.red_total       = exp_red;
            summary.green_total     = exp_green;
            summary.blue_total      = exp_blue;
            summary.bright_red      = best_red;
            summary.bright_green    = best_green;
            summary.bright_blue     = best_blue;
            expected_stats.push_back(summary);
            clear_image();
        end
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        fold_pixel(r, g, b, last);
        pixels_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_stats.size() > 0) @(posedge aclk);
    endtask

    // result side back-pressure
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        pcs_pkg::pcs_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = pcs_pkg::pcs_result_t'(m_tdata);
            if (expected_stats.size() == 0) begin
                $error("result beat with no image pending");
                error_count++;
            end else begin
                want = expected_stats.pop_front();
                check_field("distinct_colors", 32'(want.distinct_colors),
                            32'(got.distinct_colors));
                check_field("pixel_total", 32'(want.pixel_total), 32'(got.pixel_total));
                check_field("red_total", want.red_total, got.red_total);
                check_field("green_total", want.green_total, got.green_total);
                check_field("blue_total", want.blue_total, got.blue_total);
                check_field("bright_red", 32'(want.bright_red), 32'(got.bright_red));
                check_field("bright_green", 32'(want.bright_green), 32'(got.bright_green));
                check_field("bright_blue", 32'(want.bright_blue), 32'(got.bright_blue));
            end
        end
    end

    // idle watchdog, covers the bitmap sweep after reset
    always @(posedge aclk) begin
        int idle_cycles;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_single_pixel();
        send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    endtask

    task automatic test_black_image();
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_brightness_ties();
        send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
        send_pixel(8'd30, 8'd20, 8'd10, 1'b0);
        send_pixel(8'd60, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd59, 1'b1);
    endtask

    task automatic test_channel_extremes();
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFE, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    // back-to-back repeats hit the bitmap read-modify-write hazard
    task automatic test_repeated_colors();
        calm = 1'b1;
        repeat (4) send_pixel(8'd7, 8'd7, 8'd7, 1'b0);
        send_pixel(8'd7, 8'd7, 8'd8, 1'b0);
        send_pixel(8'd7, 8'd7, 8'd7, 1'b1);
        send_pixel(8'd9, 8'd9, 8'd9, 1'b1);
        send_pixel(8'd9, 8'd9, 8'd9, 1'b1);
        calm = 1'b0;
    endtask

    task automatic test_random_images();
        int         len, mode;
        logic [23:0] palette[4];
        logic [23:0] color, prev;
        bit         drained;
        drained = 1'b0;
        prev    = '0;
        while (pixels_sent < PIXEL_BUDGET) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 40);
            mode = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
            foreach (palette[i]) palette[i] = 24'($urandom);
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: color = palette[$urandom_range(0, 3)];
                    1: color = ($urandom_range(0, 1) == 0) ? prev : 24'($urandom);
                    default: color = 24'($urandom);
                endcase
                prev = color;
                send_pixel(color[7:0], color[15:8], color[23:16], i == len - 1);
            end
            if (!drained && pixels_sent > PIXEL_BUDGET / 2) begin
                wait_for_results();
                drained = 1'b1;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        clear_image();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_single_pixel();
        test_black_image();
        test_brightness_ties();
        test_channel_extremes();
        test_repeated_colors();
        test_random_images();
        wait_for_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
